>>> design/pls_pkg.sv
// Package for the positional list store: operation and status codes,
// default capacity and the command/status bundles between controller and datapath.
// No dependencies.
package pls_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int LEN_W = 5;
    localparam int VAL_W = 32;
    localparam int POS_W = 8;

    typedef enum logic [2:0] {
        KIND_INS_HEAD = 3'd0,
        KIND_INS_TAIL = 3'd1,
        KIND_INS_POS  = 3'd2,
        KIND_DEL_POS  = 3'd3,
        KIND_DUMP     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    typedef struct packed {
        logic exec;
        logic dump_start;
        logic dump_step;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic dump_last;
    } sts_t;

endpackage

>>> design/positional_list_store_top.sv
// Top level of the positional list store: stream ports, controller and datapath.
// Depends on pls_pkg, pls_ctrl and pls_datapath.
//
// Ordered list of up to CAPACITY signed 32-bit values held in a row of
// registers that shifts by one place. Insert at head, tail or a 1-based
// position, and delete at a 1-based position, each give one status
// transfer carrying the new length; an insert into a full list reports
// full, a bad position reports out of range. A dump first loads the dump
// counter and then streams the elements head first from the first cell
// while the row rotates back into place, with tlast on the final element;
// a dump of an empty list gives one transfer with status empty. A new item
// is taken in a cycle where the output register is free or being read;
// during a dump no item is taken.
module positional_list_store_top
#(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position[7:0], value[39:8]
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // length[4:0], element[36:5], zero[39:37]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);

    pls_pkg::cmd_t                      cmd;
    pls_pkg::sts_t                      sts;
    logic [pls_pkg::LEN_W-1:0]          res_length;
    logic signed [pls_pkg::VAL_W-1:0]   res_element;

    pls_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .kind          (s_axis_tuser),
        .sts           (sts),
        .cmd           (cmd)
    );

    pls_datapath
    #(
        .CAPACITY (CAPACITY)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (s_axis_tuser),
        .position      (s_axis_tdata[7:0]),
        .value         (s_axis_tdata[39:8]),
        .m_axis_tready (m_axis_tready),
        .res_valid     (m_axis_tvalid),
        .res_status    (m_axis_tuser),
        .res_length    (res_length),
        .res_element   (res_element),
        .res_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, res_element, res_length};

endmodule

>>> design/pls_ctrl.sv
// Controller of the positional list store: accepts items and sequences dumps.
// Depends on pls_pkg.
module pls_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [2:0]      kind,
    input  pls_pkg::sts_t   sts,
    output pls_pkg::cmd_t   cmd
);

    pls_pkg::state_t state_reg;
    pls_pkg::state_t state_next;
    logic            accept;
    logic            is_dump;

    assign is_dump = (kind == pls_pkg::KIND_DUMP) && !sts.count_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pls_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pls_pkg::S_IDLE:
            begin
                if (s_axis_tvalid && sts.out_free && is_dump)
                begin
                    state_next = pls_pkg::S_DUMP;
                end
            end
            pls_pkg::S_DUMP:
            begin
                if (sts.out_free && sts.dump_last)
                begin
                    state_next = pls_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pls_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready  = 1'b0;
        accept         = 1'b0;
        cmd.exec       = 1'b0;
        cmd.dump_start = 1'b0;
        cmd.dump_step  = 1'b0;
        case (state_reg)
            pls_pkg::S_IDLE:
            begin
                s_axis_tready  = sts.out_free;
                accept         = s_axis_tvalid && sts.out_free;
                cmd.exec       = accept && !is_dump;
                cmd.dump_start = accept && is_dump;
            end
            pls_pkg::S_DUMP:
            begin
                cmd.dump_step = sts.out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/pls_datapath.sv
// Datapath of the positional list store: shiftable cell row, element count,
// dump counter and the output register. Depends on pls_pkg.
module pls_datapath
#(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  pls_pkg::cmd_t                      cmd,
    output pls_pkg::sts_t                      sts,
    input  logic [2:0]                         kind,
    input  logic [pls_pkg::POS_W-1:0]          position,
    input  logic signed [pls_pkg::VAL_W-1:0]   value,
    input  logic                               m_axis_tready,
    output logic                               res_valid,
    output logic [1:0]                         res_status,
    output logic [pls_pkg::LEN_W-1:0]          res_length,
    output logic signed [pls_pkg::VAL_W-1:0]   res_element,
    output logic                               res_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = pls_pkg::POS_W + 1;

    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic [CW-1:0]                     remain_reg;
    logic [CW-1:0]                     remain_next;
    logic signed [pls_pkg::VAL_W-1:0]  cells_reg [CAPACITY];
    logic signed [pls_pkg::VAL_W-1:0]  cells_next [CAPACITY];
    logic signed [pls_pkg::VAL_W-1:0]  prev_cell [CAPACITY];
    logic signed [pls_pkg::VAL_W-1:0]  succ_cell [CAPACITY];
    logic                              do_ins;
    logic                              do_del;
    logic [CW-1:0]                     idx;
    pls_pkg::status_t                  st;

    logic                              out_valid_reg;
    pls_pkg::status_t                  out_status_reg;
    logic [pls_pkg::LEN_W-1:0]         out_length_reg;
    logic signed [pls_pkg::VAL_W-1:0]  out_element_reg;
    logic                              out_last_reg;
    logic                              out_free;

    assign out_free       = !out_valid_reg || m_axis_tready;
    assign sts.out_free   = out_free;
    assign sts.count_zero = (count_reg == '0);
    assign sts.dump_last  = (remain_reg == CW'(1));

    always_comb
    begin
        do_ins = 1'b0;
        do_del = 1'b0;
        idx    = '0;
        st     = pls_pkg::ST_OK;
        if (cmd.exec)
        begin
            case (kind)
                pls_pkg::KIND_INS_HEAD, pls_pkg::KIND_INS_TAIL, pls_pkg::KIND_INS_POS:
                begin
                    if (count_reg == CW'(CAPACITY))
                    begin
                        st = pls_pkg::ST_FULL;
                    end
                    else if (kind == pls_pkg::KIND_INS_HEAD)
                    begin
                        do_ins = 1'b1;
                    end
                    else if (kind == pls_pkg::KIND_INS_TAIL)
                    begin
                        idx    = count_reg;
                        do_ins = 1'b1;
                    end
                    else if (position == '0 || PW'(position) > (PW'(count_reg) + PW'(1)))
                    begin
                        st = pls_pkg::ST_BADPOS;
                    end
                    else
                    begin
                        idx    = CW'(position - pls_pkg::POS_W'(1));
                        do_ins = 1'b1;
                    end
                end
                pls_pkg::KIND_DEL_POS:
                begin
                    if (position == '0 || PW'(position) > PW'(count_reg))
                    begin
                        st = pls_pkg::ST_BADPOS;
                    end
                    else
                    begin
                        idx    = CW'(position - pls_pkg::POS_W'(1));
                        do_del = 1'b1;
                    end
                end
                pls_pkg::KIND_DUMP:
                begin
                    st = pls_pkg::ST_EMPTY;
                end
                default:
                begin
                    st = pls_pkg::ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        remain_next = remain_reg;
        if (cmd.dump_start)
        begin
            remain_next = count_reg;
        end
        else if (cmd.dump_step)
        begin
            remain_next = remain_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            remain_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            remain_reg <= remain_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX  = CW'(i);
        localparam logic [CW-1:0] IDX1 = CW'(i + 1);

        if (i == 0)
        begin : g_first
            assign prev_cell[i] = cells_reg[0];
        end
        else
        begin : g_prev
            assign prev_cell[i] = cells_reg[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_final
            assign succ_cell[i] = cells_reg[0];
        end
        else
        begin : g_succ
            assign succ_cell[i] = cells_reg[i+1];
        end

        always_comb
        begin
            cells_next[i] = cells_reg[i];
            if (do_ins)
            begin
                if (IDX == idx)
                begin
                    cells_next[i] = value;
                end
                else if (IDX > idx && IDX <= count_reg)
                begin
                    cells_next[i] = prev_cell[i];
                end
            end
            else if (do_del)
            begin
                if (IDX >= idx && IDX1 < count_reg)
                begin
                    cells_next[i] = succ_cell[i];
                end
            end
            else if (cmd.dump_step)
            begin
                // rotate the occupied part by one place toward the head
                if (IDX1 < count_reg)
                begin
                    cells_next[i] = succ_cell[i];
                end
                else if (IDX1 == count_reg)
                begin
                    cells_next[i] = cells_reg[0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            cells_reg[i] <= cells_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec || cmd.dump_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_status_reg  <= st;
            out_length_reg  <= pls_pkg::LEN_W'(count_next);
            out_element_reg <= '0;
            out_last_reg    <= 1'b1;
        end
        else if (cmd.dump_step)
        begin
            out_status_reg  <= pls_pkg::ST_OK;
            out_length_reg  <= pls_pkg::LEN_W'(count_reg);
            out_element_reg <= cells_reg[0];
            out_last_reg    <= (remain_reg == CW'(1));
        end
    end

    assign res_valid   = out_valid_reg;
    assign res_status  = out_status_reg;
    assign res_length  = out_length_reg;
    assign res_element = out_element_reg;
    assign res_last    = out_last_reg;

endmodule

>>> dv/tb_positional_list_store_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_store_top: directed and random list
// operations with random stalls on both stream sides, checked against a queue-based
// shadow of the list. Depends on pls_pkg and the RTL of the block.
module tb_positional_list_store_top;

    import pls_pkg::*;

    localparam int          LIST_CAP        = CAPACITY_DEF;
    localparam int          RANDOM_OPS      = 480;
    localparam logic [2:0]  KIND_RSVD_FIRST = 3'd5;
    localparam logic [2:0]  KIND_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  position;
        logic [31:0] value;
    } list_op_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  length;
        logic [31:0] element;
        logic        last;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    list_op_t     ops_to_send[$];
    list_result_t results_due[$];
    logic [31:0]  shadow_list[$];

    list_op_t     op_on_bus;
    list_result_t due;
    int           send_gap;
    int           recv_stall;
    bit           send_burst;
    bit           recv_burst;
    int           plan_len;
    int           n_total;
    int           n_accepted;
    int           n_results;
    int           n_dumps;
    int           n_full;
    int           n_badpos;
    int           n_errors;

    positional_list_store_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    function automatic list_result_t status_result(status_t st);
        list_result_t r;
        r.status  = st;
        r.length  = 5'(shadow_list.size());
        r.element = '0;
        r.last    = 1'b1;
        return r;
    endfunction

    // Update the shadow list for one accepted operation and queue its results.
    function automatic void apply_list_op(list_op_t op);
        status_t      st;
        int           idx;
        int           len;
        list_result_t r;
        st  = ST_OK;
        idx = -1;
        len = shadow_list.size();
        case (op.kind)
            KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_POS:
            begin
                if (len >= LIST_CAP)
                    st = ST_FULL;
                else if (op.kind == KIND_INS_HEAD)
                    idx = 0;
                else if (op.kind == KIND_INS_TAIL)
                    idx = len;
                else if (op.position == 0 || op.position > len + 1)
                    st = ST_BADPOS;
                else
                    idx = op.position - 1;
                if (idx >= 0)
                    shadow_list.insert(idx, op.value);
            end
            KIND_DEL_POS:
            begin
                if (op.position == 0 || op.position > len)
                    st = ST_BADPOS;
                else
                    shadow_list.delete(op.position - 1);
            end
            KIND_DUMP:
            begin
                n_dumps++;
                if (len == 0)
                    st = ST_EMPTY;
            end
            default:
            begin
            end
        endcase
        if (st == ST_FULL)
            n_full++;
        if (st == ST_BADPOS)
            n_badpos++;
        if (op.kind == KIND_DUMP && len > 0)
        begin
            for (int i = 0; i < len; i++)
            begin
                r.status  = ST_OK;
                r.length  = 5'(len);
                r.element = shadow_list[i];
                r.last    = (i == len - 1);
                results_due.push_back(r);
            end
        end
        else
            results_due.push_back(status_result(st));
    endfunction

    // Queue an operation and track the length it leaves behind.
    function automatic void add_op(logic [2:0] kind, logic [7:0] position, logic [31:0] value);
        list_op_t op;
        op.kind     = kind;
        op.position = position;
        op.value    = value;
        ops_to_send.push_back(op);
        n_total++;
        if ((kind == KIND_INS_HEAD || kind == KIND_INS_TAIL) && plan_len < LIST_CAP)
            plan_len++;
        else if (kind == KIND_INS_POS && plan_len < LIST_CAP && position != 0
                 && position <= plan_len + 1)
            plan_len++;
        else if (kind == KIND_DEL_POS && position != 0 && position <= plan_len)
            plan_len--;
    endfunction

    function automatic logic [7:0] pick_position(bit for_insert);
        int top;
        top = for_insert ? plan_len + 1 : plan_len;
        if (top == 0 || $urandom_range(0, 99) < 12)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(1, top));
    endfunction

    // Driver: present queued operations with random gaps between transfers.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_list_op(op_on_bus);
                n_accepted++;
                send_gap = send_burst ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 31) == 0)
                    send_burst = !send_burst;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0 || ops_to_send.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    op_on_bus = ops_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {op_on_bus.value, op_on_bus.position};
                    s_axis_tuser  <= op_on_bus.kind;
                end
            end
        end
    end

    // Monitor: check each result transfer, then stall for a random number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results++;
                if (results_due.size() == 0)
                begin
                    $error("unexpected result: status %0d length %0d element %0h",
                           m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[36:5]);
                    n_errors++;
                end
                else
                begin
                    due = results_due.pop_front();
                    if (m_axis_tuser !== due.status)
                    begin
                        $error("status: expected %0d, got %0d", due.status, m_axis_tuser);
                        n_errors++;
                    end
                    if (m_axis_tdata[4:0] !== due.length)
                    begin
                        $error("length: expected %0d, got %0d", due.length, m_axis_tdata[4:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[36:5] !== due.element)
                    begin
                        $error("element: expected %0h, got %0h", due.element,
                               m_axis_tdata[36:5]);
                        n_errors++;
                    end
                    if (m_axis_tlast !== due.last)
                    begin
                        $error("last: expected %0b, got %0b", due.last, m_axis_tlast);
                        n_errors++;
                    end
                end
                recv_stall = recv_burst ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 31) == 0)
                    recv_burst = !recv_burst;
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int  roll;
        int  waited;
        bit  growing;
        logic [2:0] k;

        // Empty list: dump, delete and out-of-range inserts; then valid inserts, a dump, reserved kinds and deletes.
        add_op(KIND_DUMP, 8'd0, 32'd0);
        add_op(KIND_DEL_POS, 8'd1, 32'd0);
        add_op(KIND_INS_POS, 8'd0, 32'h1234_5678);
        add_op(KIND_INS_POS, 8'd2, 32'h1234_5678);
        add_op(KIND_INS_TAIL, 8'd255, 32'h7FFF_FFFF);
        add_op(KIND_INS_HEAD, 8'd0, 32'h8000_0000);
        add_op(KIND_INS_POS, 8'd3, 32'hFFFF_FFFF);
        add_op(KIND_INS_POS, 8'd2, 32'h0000_0000);
        add_op(KIND_DUMP, 8'd255, 32'hFFFF_FFFF);
        add_op(KIND_RSVD_FIRST, 8'd255, 32'hFFFF_FFFF);
        add_op(KIND_RSVD_LAST, 8'd0, 32'd0);
        add_op(KIND_DEL_POS, 8'd4, 32'd0);
        add_op(KIND_DEL_POS, 8'd1, 32'd0);
        add_op(KIND_DEL_POS, 8'd0, 32'd0);
        add_op(KIND_DEL_POS, 8'd255, 32'd0);
        add_op(KIND_DEL_POS, 8'd3, 32'd0);
        // Fill to capacity, then hit the full list with every insert kind.
        while (plan_len < LIST_CAP)
        begin
            k = 3'($urandom_range(KIND_INS_HEAD, KIND_INS_POS));
            add_op(k, pick_position(1'b1), $urandom);
        end
        add_op(KIND_INS_HEAD, 8'd1, 32'hA5A5_A5A5);
        add_op(KIND_INS_POS, 8'd255, 32'h5A5A_5A5A);
        add_op(KIND_INS_TAIL, 8'd17, 32'h0F0F_0F0F);
        add_op(KIND_DUMP, 8'd0, 32'd0);

        growing = 1'b0;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 40 == 0)
                growing = $urandom_range(0, 1);
            roll = $urandom_range(0, 99);
            if (roll < 3)
                add_op(3'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST)),
                       8'($urandom_range(0, 255)), $urandom);
            else if (roll < 12)
                add_op(KIND_DUMP, 8'($urandom_range(0, 255)), $urandom);
            else if (roll < (growing ? 82 : 42))
            begin
                k = 3'($urandom_range(KIND_INS_HEAD, KIND_INS_POS));
                add_op(k, (k == KIND_INS_POS) ? pick_position(1'b1)
                                              : 8'($urandom_range(0, 255)), $urandom);
            end
            else
                add_op(KIND_DEL_POS, pick_position(1'b0), $urandom);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_total)
            @(posedge clk);
        waited = 0;
        while (results_due.size() > 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (results_due.size() > 0)
        begin
            $error("%0d expected results never arrived", results_due.size());
            n_errors++;
        end

        $display("Ran %0d list operations (%0d dumps), checked %0d result transfers.",
                 n_accepted, n_dumps, n_results);
        $display("Inserts refused on a full list: %0d, out-of-range positions: %0d.",
                 n_full, n_badpos);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> positional_list_store_top.f
design/pls_pkg.sv
design/pls_ctrl.sv
design/pls_datapath.sv
design/positional_list_store_top.sv
dv/tb_positional_list_store_top.sv
